// ===== hdl/asa_pkg.sv =====
`timescale 1ns / 1ps

package asa_pkg;

   localparam int HEADER_BYTES = 16;
   localparam int HEADER_ALIGN = 8;
   localparam int MAX_FRAMES   = 64;

   localparam int ADDR_W   = 32;
   localparam int ALIGN_W  = 16;
   localparam int LOG2_W   = 4;
   localparam int FRAME_AW = $clog2(MAX_FRAMES);
   localparam int COUNT_W  = $clog2(MAX_FRAMES + 1);
   localparam int CSR_W    = 1;

   localparam logic [ALIGN_W-1:0] HEADER_MASK = ALIGN_W'(HEADER_ALIGN - 1);

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      STATUS_OK      = 3'd0,
      STATUS_OOM     = 3'd1,
      STATUS_EMPTY   = 3'd2,
      STATUS_NOT_TOP = 3'd3,
      STATUS_FULL    = 3'd4
   } status_type;

   typedef enum logic [CSR_W-1:0] {
      CSR_BASE_ADDRESS = 1'b0,
      CSR_CAPACITY     = 1'b1
   } csr_type;

   typedef struct packed {
      op_type              op;
      logic [ADDR_W-1:0]   request_size;
      logic [LOG2_W-1:0]   align_log2;
      logic [ADDR_W-1:0]   free_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   payload_address;
      status_type          status;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   start;
      logic [ADDR_W-1:0]   payload;
   } frame_type;

endpackage

// ===== hdl/asa_frame_ram.sv =====
`timescale 1ns / 1ps

module asa_frame_ram
   import asa_pkg::*;
(
   input  logic                clock,
   input  logic                wr_en,
   input  logic [FRAME_AW-1:0] wr_addr,
   input  frame_type           wr_data,
   input  logic [FRAME_AW-1:0] rd_addr,
   output frame_type           rd_data
);

   frame_type mem [MAX_FRAMES];
   frame_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/asa_core.sv =====
`timescale 1ns / 1ps

module asa_core
   import asa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [CSR_W-1:0]  csr_index,
   input  logic [ADDR_W-1:0] csr_wdata,
   input  logic              fire,
   input  req_type           req,
   output rsp_type           rsp
);

   logic [ADDR_W-1:0]  base_ff, base_in;
   logic [ADDR_W-1:0]  cap_ff, cap_in;
   logic [ADDR_W-1:0]  top_ff, top_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   frame_type          tos_ff, tos_in;

   frame_type          below;
   frame_type          new_frame;
   logic               push;
   logic [FRAME_AW-1:0] rd_addr;

   logic [ADDR_W-1:0]  first;
   logic [ALIGN_W-1:0] align_mask;
   logic [ALIGN_W-1:0] pad;
   logic [ADDR_W-1:0]  payload;
   logic [ADDR_W:0]    total;
   logic [ADDR_W-1:0]  used;
   logic [ADDR_W-1:0]  avail;
   logic               full;
   logic               oom;

   // Allocate arithmetic
   always_comb begin
      first      = top_ff + ADDR_W'(HEADER_BYTES);
      align_mask = ~({ALIGN_W{1'b1}} << req.align_log2) | HEADER_MASK;
      pad        = (~first[ALIGN_W-1:0] + ALIGN_W'(1)) & align_mask;
      payload    = first + ADDR_W'(pad);
      total      = {1'b0, req.request_size} + (ADDR_W+1)'(pad)
                   + (ADDR_W+1)'(HEADER_BYTES);
      used       = top_ff - base_ff;
      avail      = (used > cap_ff) ? '0 : cap_ff - used;
      full       = (count_ff >= COUNT_W'(MAX_FRAMES));
      oom        = ({1'b0, avail} < total);
   end

   always_comb begin
      base_in   = base_ff;
      cap_in    = cap_ff;
      top_in    = top_ff;
      count_in  = count_ff;
      tos_in    = tos_ff;
      push      = 1'b0;
      new_frame = '{start: top_ff, payload: payload};
      rsp       = '{payload_address: '0, status: STATUS_OK};

      unique case (req.op)
         OP_ALLOC: begin
            priority if (full) begin
               rsp.status = STATUS_FULL;
            end else if (oom) begin
               rsp.status = STATUS_OOM;
            end else begin
               rsp.payload_address = payload;
               push = fire;
            end
         end
         OP_FREE: begin
            priority if (count_ff == '0) begin
               rsp.status = STATUS_EMPTY;
            end else if (req.free_address != '0 && req.free_address != tos_ff.payload) begin
               rsp.status = STATUS_NOT_TOP;
            end else begin
               // roll back to the frame start, the frame below becomes top
               if (fire) begin
                  top_in   = tos_ff.start;
                  count_in = count_ff - COUNT_W'(1);
                  tos_in   = below;
               end
            end
         end
         default: rsp.status = STATUS_OK;
      endcase

      if (push) begin
         top_in   = payload + req.request_size;
         count_in = count_ff + COUNT_W'(1);
         tos_in   = new_frame;
      end

      if (csr_we) begin
         unique case (csr_type'(csr_index))
            CSR_BASE_ADDRESS: begin
               base_in  = csr_wdata;
               top_in   = csr_wdata;
               count_in = '0;
            end
            CSR_CAPACITY: cap_in = csr_wdata;
            default: cap_in = cap_ff;
         endcase
      end

      // keep the frame below the new top on the read port
      rd_addr = count_in[FRAME_AW-1:0] - FRAME_AW'(2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         cap_ff   <= '0;
         top_ff   <= '0;
         count_ff <= '0;
      end else begin
         base_ff  <= base_in;
         cap_ff   <= cap_in;
         top_ff   <= top_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      tos_ff <= tos_in;
   end

   asa_frame_ram u_frame_ram (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (count_ff[FRAME_AW-1:0]),
      .wr_data (new_frame),
      .rd_addr (rd_addr),
      .rd_data (below)
   );

endmodule

// ===== hdl/aligned_stack_allocator.sv =====
`timescale 1ns / 1ps

// LIFO region allocator over the buffer [base, base + capacity). An allocate
// pads top + header up to max(2^align_log2, header alignment), checks free
// space and the frame count and pushes a frame (old top, payload address); a
// free pops the top frame and rolls the top back. One request is taken per
// cycle while the response slot is free or draining; rsp_ready low holds the
// flow. A taken request is held in the request register, then the
// allocate/free logic loads its response into the response register. The
// top frame sits in flops and the frame memory's registered read port always
// holds the frame below it, so back-to-back frees need no stall. Write
// base_address to reset the allocator (top returns to base, frame stack
// emptied); capacity can be rewritten without touching the frames. Write
// configuration only while idle.
module aligned_stack_allocator
   import asa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,

   input  logic              csr_we,
   input  logic [CSR_W-1:0]  csr_index,
   input  logic [ADDR_W-1:0] csr_wdata,

   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_op,
   input  logic [ADDR_W-1:0] req_request_size,
   input  logic [LOG2_W-1:0] req_align_log2,
   input  logic [ADDR_W-1:0] req_free_address,

   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [ADDR_W-1:0] rsp_payload_address,
   output logic [2:0]        rsp_status
);

   // request register
   logic    req_valid_ff, req_valid_in;
   req_type req_ff, req_in;

   // response register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   rsp_type core_rsp;
   logic    advance;
   logic    req_take;

   // Advance the held request whenever the response slot is free or draining.
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      req_valid_in = req_valid_ff;
      req_in       = req_ff;
      if (req_take) begin
         req_valid_in = 1'b1;
         req_in       = '{op:           op_type'(req_op),
                          request_size: req_request_size,
                          align_log2:   req_align_log2,
                          free_address: req_free_address};
      end else if (advance) begin
         req_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_in       = core_rsp;
      end else if (rsp_ready) begin
         // drop the delivered response
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers hold without reset
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   asa_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .fire      (advance),
      .req       (req_ff),
      .rsp       (core_rsp)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_payload_address = rsp_ff.payload_address;
   assign rsp_status          = rsp_ff.status;

endmodule
